### hw/rtl/fstf_pkg.sv
`timescale 1ns / 1ps

package fstf_pkg;

  localparam int CELL_BITS      = 16;
  localparam int WORD_BITS      = 32;
  localparam int BIT_IDX_W      = 5;
  localparam int HALF_TRACK_MAX = 79;
  localparam int CYLINDERS      = HALF_TRACK_MAX / 2 + 1;
  localparam int ROWS           = 2 * CYLINDERS;
  localparam int ROW_W          = 7;
  localparam int WORD_IDX_W     = CELL_BITS - BIT_IDX_W;
  localparam int ADDR_W         = ROW_W + WORD_IDX_W;
  localparam int MEM_DEPTH      = ROWS * (1 << WORD_IDX_W);

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_DATA    = 2'd2,
    MODE_LOAD    = 2'd3
  } mode_t;

  function automatic logic [7:0] cancel_phases(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((r & 8'h05) == 8'h05) r = r & 8'hFA;
    if ((r & 8'h0A) == 8'h0A) r = r & 8'hF5;
    return r;
  endfunction

  function automatic logic [6:0] step_half(input logic [6:0] h, input logic en,
                                           input logic out_s, input logic in_s);
    logic [6:0] t;
    t = h;
    if (en && out_s && t != 7'd0) t = t - 7'd1;
    if (en && in_s && t < 7'(HALF_TRACK_MAX)) t = t + 7'd1;
    return t;
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic drive, input logic [5:0] cyl);
    return drive ? ROW_W'(CYLINDERS) + ROW_W'(cyl) : ROW_W'(cyl);
  endfunction

endpackage

### hw/rtl/floppy_stepper_track_and_flux_reader.sv
`timescale 1ns / 1ps

// Two-drive floppy interface over a bit-per-cell track store held in one synchronous
// memory of 32-cell words. After reset the block clears all 163840 words, one word a cycle,
// with busy high. A transaction is taken when start is high and busy is low; its single
// result appears on read_data for one cycle with done high and must be captured then.
// Loads and control writes with a pending write update memory by read-modify-write of
// each word touched, once per selected drive.

module floppy_stepper_track_and_flux_reader (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] control,
  input  logic [15:0] position,
  input  logic       load_drive,
  input  logic [5:0] load_cylinder,
  input  logic       load_bit,
  output logic [7:0] read_data,
  output logic       done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_SCAN
  } state_t;

  state_t state;

  logic [fstf_pkg::WORD_BITS-1:0] mem [0:fstf_pkg::MEM_DEPTH-1];
  logic [fstf_pkg::WORD_BITS-1:0] rdata;
  logic [fstf_pkg::ADDR_W-1:0]    raddr;
  logic [fstf_pkg::ADDR_W-1:0]    waddr;
  logic [fstf_pkg::WORD_BITS-1:0] wdata;
  logic                           wen;

  logic [6:0]  h1;
  logic [6:0]  h2;
  logic [7:0]  latch;
  logic [15:0] last_write;
  logic [15:0] poll_pos;
  logic        prev_bit;
  logic        flag;
  logic [7:0]  dsr;

  logic [fstf_pkg::ADDR_W-1:0] clr_addr;
  logic [7:0]  ctl_in;
  logic [15:0] pos_in;
  logic        is_load;
  logic        is_data;
  logic [fstf_pkg::ROW_W-1:0] frow;
  logic [15:0] fcell;
  logic [15:0] fcnt;
  logic [15:0] fcount_all;
  logic        fbit;
  logic        fsecond;
  logic [fstf_pkg::BIT_IDX_W-1:0] bidx;

  // step logic
  logic [7:0] now_c;
  logic [7:0] old_c;
  logic [3:0] ph;
  logic       step_out;
  logic       step_in;
  logic [6:0] h1_next;
  logic [6:0] h2_next;

  assign now_c = fstf_pkg::cancel_phases(control);
  assign old_c = fstf_pkg::cancel_phases(latch);
  assign ph    = now_c[3:0];
  assign step_out = (ph == 4'h1 && old_c[1]) || (ph == 4'h2 && old_c[2]) ||
                    (ph == 4'h4 && old_c[3]) || (ph == 4'h8 && old_c[0]);
  assign step_in  = (ph == 4'h1 && old_c[3]) || (ph == 4'h2 && old_c[0]) ||
                    (ph == 4'h4 && old_c[1]) || (ph == 4'h8 && old_c[2]);
  assign h1_next = fstf_pkg::step_half(h1, now_c[4], step_out, step_in);
  assign h2_next = fstf_pkg::step_half(h2, now_c[7], step_out, step_in);

  // scan setup
  logic        have;
  logic [fstf_pkg::ROW_W-1:0] scan_row;
  logic [15:0] last_cell;
  logic [15:0] pos_dist;

  assign have      = latch[4] | latch[7];
  assign scan_row  = latch[4] ? fstf_pkg::row_of(1'b0, h1[6:1])
                              : fstf_pkg::row_of(1'b1, h2[6:1]);
  assign last_cell = position - 16'd1;
  assign pos_dist  = position - last_write;

  // fill word mask
  logic [5:0]  avail;
  logic [5:0]  take;
  logic [32:0] low_ones;
  logic [fstf_pkg::WORD_BITS-1:0] fmask;

  assign avail    = 6'd32 - {1'b0, fcell[4:0]};
  assign take     = (fcnt < 16'(avail)) ? fcnt[5:0] : avail;
  assign low_ones = ~({33{1'b1}} << take);
  assign fmask    = low_ones[31:0] << fcell[4:0];

  always_comb begin
    raddr = {scan_row, last_cell[15:5]};
    if (state == S_FILL_RD) raddr = {frow, fcell[15:5]};
  end

  assign wen   = (state == S_CLEAR) || (state == S_FILL_WR);
  assign waddr = (state == S_CLEAR) ? clr_addr : {frow, fcell[15:5]};
  assign wdata = (state == S_CLEAR) ? '0 : ((rdata & ~fmask) | (fbit ? fmask : '0));

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign busy = (state != S_IDLE);

  logic scan_v;
  logic new_flag;
  assign scan_v   = rdata[bidx];
  assign new_flag = flag ^ prev_bit ^ scan_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      h1         <= '0;
      h2         <= '0;
      latch      <= '0;
      last_write <= '0;
      poll_pos   <= '0;
      prev_bit   <= 1'b0;
      flag       <= 1'b0;
      dsr        <= '0;
      done       <= 1'b0;
      read_data  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == fstf_pkg::ADDR_W'(fstf_pkg::MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            ctl_in  <= control;
            pos_in  <= position;
            is_load <= (mode == fstf_pkg::MODE_LOAD);
            is_data <= (mode == fstf_pkg::MODE_DATA);
            unique case (fstf_pkg::mode_t'(mode))
              fstf_pkg::MODE_CONTROL: begin
                h1 <= h1_next;
                h2 <= h2_next;
                if (!latch[6] && pos_dist != 16'd0 && have) begin
                  fcell      <= last_write;
                  fcnt       <= pos_dist;
                  fcount_all <= pos_dist;
                  fbit       <= latch[5];
                  fsecond    <= latch[4] & latch[7];
                  frow       <= latch[4] ? fstf_pkg::row_of(1'b0, h1_next[6:1])
                                         : fstf_pkg::row_of(1'b1, h2_next[6:1]);
                  state      <= S_FILL_RD;
                end else begin
                  latch      <= control;
                  last_write <= position;
                  read_data  <= control;
                  done       <= 1'b1;
                end
              end
              fstf_pkg::MODE_POLL, fstf_pkg::MODE_DATA: begin
                poll_pos <= position;
                if (position != poll_pos && have) begin
                  bidx  <= last_cell[4:0];
                  state <= S_SCAN;
                end else begin
                  logic nf;
                  nf = flag;
                  if (position != poll_pos) begin
                    nf = flag ^ prev_bit;
                    prev_bit <= 1'b0;
                  end
                  if (mode == fstf_pkg::MODE_DATA) begin
                    dsr       <= {dsr[6:0], ~nf};
                    read_data <= {dsr[6:0], ~nf};
                    flag      <= 1'b0;
                  end else begin
                    flag      <= nf;
                    read_data <= {nf, 7'd0};
                  end
                  done <= 1'b1;
                end
              end
              fstf_pkg::MODE_LOAD: begin
                if (load_cylinder < 6'(fstf_pkg::CYLINDERS)) begin
                  fcell   <= position;
                  fcnt    <= 16'd1;
                  fbit    <= load_bit;
                  fsecond <= 1'b0;
                  frow    <= fstf_pkg::row_of(load_drive, load_cylinder);
                  state   <= S_FILL_RD;
                end else begin
                  read_data <= '0;
                  done      <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          if (fcnt != 16'(take)) begin
            fcell <= fcell + 16'(take);
            fcnt  <= fcnt - 16'(take);
            state <= S_FILL_RD;
          end else if (fsecond) begin
            fsecond <= 1'b0;
            fcell   <= last_write;
            fcnt    <= fcount_all;
            frow    <= fstf_pkg::row_of(1'b1, h2[6:1]);
            state   <= S_FILL_RD;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (is_load) begin
              read_data <= '0;
            end else begin
              latch      <= ctl_in;
              last_write <= pos_in;
              read_data  <= ctl_in;
            end
          end
        end
        S_SCAN: begin
          prev_bit <= scan_v;
          if (is_data) begin
            dsr       <= {dsr[6:0], ~new_flag};
            read_data <= {dsr[6:0], ~new_flag};
            flag      <= 1'b0;
          end else begin
            flag      <= new_flag;
            read_data <= {new_flag, 7'd0};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/floppy_stepper_track_and_flux_reader_checker.sv
`timescale 1ns / 1ps

module floppy_stepper_track_and_flux_reader_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  control,
  input  logic [15:0] position,
  input  logic        load_drive,
  input  logic [5:0]  load_cylinder,
  input  logic        load_bit,
  input  logic [7:0]  read_data,
  input  logic        done,
  output int          errors,
  output int          pending
);

  localparam int TRACK = 65536;
  localparam logic [7:0] DRIVE1   = 8'h10;
  localparam logic [7:0] WR_BIT   = 8'h20;
  localparam logic [7:0] WR_REQ_N = 8'h40;
  localparam logic [7:0] DRIVE2   = 8'h80;

  bit         cells[int];
  logic [6:0] half1, half2;
  logic [7:0] latch_q, shreg;
  logic [15:0] wpos, ppos;
  logic       prev_bit, flag;
  logic [7:0] expected_bytes[$];

  function automatic logic [7:0] opposed_off(logic [7:0] c);
    if ((c & 8'h05) == 8'h05) c &= 8'hFA;
    if ((c & 8'h0A) == 8'h0A) c &= 8'hF5;
    return c;
  endfunction

  function automatic int cell_at(int drive, int cyl, int cell_no);
    return (drive * fstf_pkg::CYLINDERS + cyl) * TRACK + cell_no;
  endfunction

  function automatic bit cell_val(int idx);
    return cells.exists(idx) ? cells[idx] : 1'b0;
  endfunction

  function automatic void fill(int drive, logic [6:0] h, logic [15:0] upto, bit v);
    logic [15:0] c;
    c = wpos;
    while (c != upto) begin
      cells[cell_at(drive, h / 2, c)] = v;
      c++;
    end
  endfunction

  function automatic void scan(logic [15:0] upto);
    logic [15:0] c;
    bit v;
    bit have;
    int drive;
    int cyl;
    c = ppos;
    have = 1;
    drive = 0;
    cyl = 0;
    if (latch_q & DRIVE1) cyl = half1 / 2;
    else if (latch_q & DRIVE2) begin
      drive = 1;
      cyl = half2 / 2;
    end else have = 0;
    while (c != upto) begin
      v = have ? cell_val(cell_at(drive, cyl, c)) : 1'b0;
      if (v != prev_bit) begin
        prev_bit = v;
        flag = ~flag;
      end
      c++;
    end
    ppos = upto;
  endfunction

  function automatic logic [7:0] access(fstf_pkg::mode_t m, logic [7:0] c, logic [15:0] p,
                                        logic ld, logic [5:0] lc, logic lb);
    logic [7:0] now, old, ph;
    logic step_out, step_in;
    case (m)
      fstf_pkg::MODE_CONTROL: begin
        now = opposed_off(c);
        old = opposed_off(latch_q);
        ph = now & 8'h0F;
        step_out = (ph == 8'h01 && old[1]) || (ph == 8'h02 && old[2]) ||
                   (ph == 8'h04 && old[3]) || (ph == 8'h08 && old[0]);
        step_in  = (ph == 8'h01 && old[3]) || (ph == 8'h02 && old[0]) ||
                   (ph == 8'h04 && old[1]) || (ph == 8'h08 && old[2]);
        if (step_out) begin
          if (now[4] && half1 > 0) half1--;
          if (now[7] && half2 > 0) half2--;
        end
        if (step_in) begin
          if (now[4] && half1 < fstf_pkg::HALF_TRACK_MAX) half1++;
          if (now[7] && half2 < fstf_pkg::HALF_TRACK_MAX) half2++;
        end
        if (!(latch_q & WR_REQ_N)) begin
          if (latch_q & DRIVE1) fill(0, half1, p, (latch_q & WR_BIT) != 0);
          if (latch_q & DRIVE2) fill(1, half2, p, (latch_q & WR_BIT) != 0);
        end
        latch_q = c;
        wpos = p;
        return c;
      end
      fstf_pkg::MODE_POLL: begin
        scan(p);
        return flag ? 8'h80 : 8'h00;
      end
      fstf_pkg::MODE_DATA: begin
        scan(p);
        shreg = {shreg[6:0], ~flag};
        flag = 0;
        return shreg;
      end
      default: begin
        if (lc < fstf_pkg::CYLINDERS) cells[cell_at(ld, lc, p)] = lb;
        return 8'h00;
      end
    endcase
  endfunction

  assign pending = expected_bytes.size();

  initial begin
    errors = 0;
    half1 = 0; half2 = 0; latch_q = 0; shreg = 0;
    wpos = 0; ppos = 0; prev_bit = 0; flag = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_bytes.size() == 0) begin
          $error("read_data: unexpected transaction, actual %02h", read_data);
          errors++;
        end else begin
          if (read_data !== expected_bytes[0]) begin
            $error("read_data: expected %02h, actual %02h", expected_bytes[0], read_data);
            errors++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      if (start && !busy)
        expected_bytes.push_back(access(fstf_pkg::mode_t'(mode), control, position,
                                        load_drive, load_cylinder, load_bit));
    end
  end

endmodule

### tb/sv/tb_floppy_stepper_track_and_flux_reader.sv
`timescale 1ns / 1ps

module tb_floppy_stepper_track_and_flux_reader;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [7:0]  control;
  logic [15:0] position;
  logic        load_drive;
  logic [5:0]  load_cylinder;
  logic        load_bit;
  logic [7:0]  read_data;
  logic        done;
  logic        busy_n;
  int          errors;
  int          pending;
  longint      cycles;

  logic [15:0] cur_pos;
  int          phase_idx;
  int          dir;

  floppy_stepper_track_and_flux_reader i_dut (
    .clk, .rst, .start, .busy, .mode, .control, .position,
    .load_drive, .load_cylinder, .load_bit, .read_data, .done
  );

  floppy_stepper_track_and_flux_reader_checker i_chk (
    .clk, .rst, .start, .busy, .mode, .control, .position,
    .load_drive, .load_cylinder, .load_bit, .read_data, .done,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // busy as it will be seen at the next rising edge
  always @(negedge clk) busy_n <= busy;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** floppy_stepper_track_and_flux_reader: FAILED **");
      $finish;
    end
  end

  task automatic issue(fstf_pkg::mode_t m, logic [7:0] c, logic [15:0] p,
                       logic ld, logic [5:0] lc, logic lb);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 7) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    control <= c;
    position <= p;
    load_drive <= ld;
    load_cylinder <= lc;
    load_bit <= lb;
    do @(posedge clk); while (busy_n);
  endtask

  task automatic ctl(logic [7:0] c, logic [15:0] p);
    issue(fstf_pkg::MODE_CONTROL, c, p, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
          1'($urandom_range(0, 1)));
  endtask

  task automatic rd(fstf_pkg::mode_t m, logic [15:0] p);
    issue(m, 8'($urandom_range(0, 255)), p, 1'($urandom_range(0, 1)),
          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_item();
    int r;
    logic [7:0] c;
    logic [3:0] ph;
    r = $urandom_range(0, 99);
    cur_pos = ($urandom_range(0, 29) == 0) ? 16'($urandom) :
              cur_pos + 16'($urandom_range(0, 300));
    if (r < 25) begin
      if ($urandom_range(0, 59) == 0) dir = -dir;
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
      else begin
        if ($urandom_range(0, 3) != 0) phase_idx = (phase_idx + dir + 4) % 4;
        ph = 4'b0001 << phase_idx;
        c = {$urandom_range(0, 1) == 0, 1'b0, 1'($urandom), $urandom_range(0, 1) == 0, ph};
        c[6] = $urandom_range(0, 2) == 0;
      end
      ctl(c, cur_pos);
    end else if (r < 55) rd(fstf_pkg::MODE_POLL, cur_pos);
    else if (r < 85) rd(fstf_pkg::MODE_DATA, cur_pos);
    else
      issue(fstf_pkg::MODE_LOAD, 8'($urandom_range(0, 255)),
            cur_pos + 16'($urandom_range(0, 200)),
            1'($urandom_range(0, 1)),
            ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5)),
            1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst = 1; start = 0; mode = fstf_pkg::MODE_CONTROL; control = 0; position = 0;
    load_drive = 0; load_cylinder = 0; load_bit = 0; cycles = 0; busy_n = 1;
    cur_pos = 0; phase_idx = 0; dir = 1;
    repeat (6) @(posedge clk);
    rst <= 0;

    // stepping out at half-track 0 saturates on both drives
    ctl(8'h91, 16'd0);
    ctl(8'h98, 16'd10);
    ctl(8'h94, 16'd20);
    ctl(8'h92, 16'd30);
    ctl(8'h91, 16'd40);
    // opposed phases cancel
    ctl(8'h9F, 16'd50);
    ctl(8'h95, 16'd60);
    // load extremes, out-of-range cylinder ignored
    issue(fstf_pkg::MODE_LOAD, 8'hFF, 16'd100, 1'b0, 6'd1, 1'b1);
    issue(fstf_pkg::MODE_LOAD, 8'h00, 16'd65535, 1'b1, 6'd39, 1'b1);
    issue(fstf_pkg::MODE_LOAD, 8'hFF, 16'd101, 1'b1, 6'd63, 1'b1);
    issue(fstf_pkg::MODE_LOAD, 8'h00, 16'd102, 1'b0, 6'd40, 1'b0);
    // pending write with wrap on drive 1, then drive 2, then no drive
    ctl(8'h31, 16'd65500);
    ctl(8'h11, 16'd40);
    ctl(8'hA1, 16'd40);
    ctl(8'h01, 16'd200);
    rd(fstf_pkg::MODE_POLL, 16'd90);
    ctl(8'h11, 16'd300);
    rd(fstf_pkg::MODE_POLL, 16'd120);
    rd(fstf_pkg::MODE_DATA, 16'd120);
    rd(fstf_pkg::MODE_DATA, 16'd65535);
    rd(fstf_pkg::MODE_POLL, 16'd0);
    ctl(8'h81, 16'd0);
    rd(fstf_pkg::MODE_DATA, 16'd300);
    ctl(8'h00, 16'd300);
    rd(fstf_pkg::MODE_POLL, 16'd400);
    cur_pos = 16'd400;

    repeat (1025) random_item();
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("** floppy_stepper_track_and_flux_reader: PASSED **");
    else $display("** floppy_stepper_track_and_flux_reader: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fstf_pkg.sv
hw/rtl/floppy_stepper_track_and_flux_reader.sv
tb/sv/floppy_stepper_track_and_flux_reader_checker.sv
tb/sv/tb_floppy_stepper_track_and_flux_reader.sv
